// ----- sv/sls_pkg.sv -----
// Shared types and constants for the 3x3 linear system solver.
// Used by every module of the solver; depends on nothing.
`default_nettype none
package sls_pkg;

  localparam int COEF_W     = 16;
  localparam int SOL_W      = 32;
  localparam int E_W        = 2 * COEF_W + 1;
  localparam int W64        = 64;
  localparam int FRAC_BITS  = 16;
  localparam int Q_BITS     = SOL_W;
  localparam int DIV_STAGES = Q_BITS + 2;
  localparam int NUM_STAGES = 3;
  localparam int ELIM_STAGES = 5;
  localparam int LATENCY    = ELIM_STAGES + 2 * NUM_STAGES + 3 * DIV_STAGES + 1;

  typedef logic signed [E_W-1:0] e_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] r1_x_coef;
    logic signed [COEF_W-1:0] r1_y_coef;
    logic signed [COEF_W-1:0] r1_z_coef;
    logic signed [COEF_W-1:0] r1_rhs;
    logic signed [COEF_W-1:0] r2_x_coef;
    logic signed [COEF_W-1:0] r2_y_coef;
    logic signed [COEF_W-1:0] r2_z_coef;
    logic signed [COEF_W-1:0] r2_rhs;
    logic signed [COEF_W-1:0] r3_x_coef;
    logic signed [COEF_W-1:0] r3_y_coef;
    logic signed [COEF_W-1:0] r3_z_coef;
    logic signed [COEF_W-1:0] r3_rhs;
  } in_t;

  typedef struct packed {
    logic signed [SOL_W-1:0] sol_x;
    logic signed [SOL_W-1:0] sol_y;
    logic signed [SOL_W-1:0] sol_z;
    logic                    unique_solution;
    logic                    overflow;
  } out_t;

  // carried alongside the z division
  typedef struct packed {
    logic uniq;
    e_t   e11, e12, e13, e21, e22, e23, e31, e32, e33;
    in_t  a;
  } zside_t;

  // carried alongside the y numerator and division
  typedef struct packed {
    logic                    uniq;
    logic                    ovf;
    logic signed [SOL_W-1:0] z;
    in_t                     a;
  } yside_t;

  // carried alongside the x numerator and division
  typedef struct packed {
    logic                    uniq;
    logic                    ovf;
    logic signed [SOL_W-1:0] y;
    logic signed [SOL_W-1:0] z;
  } xside_t;

endpackage
`default_nettype wire

// ----- sv/sls_elim.sv -----
// Elimination front end: first and second elimination terms, determinant test,
// and z pivot selection, in five register stages. Depends on sls_pkg.
`default_nettype none
module sls_elim (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  input  sls_pkg::in_t                       a_i,
  output logic                               valid_o,
  output logic signed [sls_pkg::W64-1:0]     num_o,
  output logic signed [sls_pkg::W64-1:0]     den_o,
  output sls_pkg::zside_t                    side_o
);

  localparam int CW = sls_pkg::COEF_W;
  localparam int EW = sls_pkg::E_W;
  localparam int W  = sls_pkg::W64;
  localparam int PW = 2 * CW;
  localparam int TW = 3 * CW;
  localparam int DW = TW + 3;
  localparam int FW = 2 * EW;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  sls_pkg::in_t a1_r, a2_r, a3_r, a4_r;

  logic signed [PW-1:0] pe_nxt [18];
  logic signed [PW-1:0] pe_r   [18];
  logic signed [PW-1:0] pd_nxt [6];
  logic signed [PW-1:0] pd_r   [6];
  logic signed [EW-1:0] e_nxt  [9];
  logic signed [EW-1:0] e2_r   [9];
  logic signed [EW-1:0] e3_r   [9];
  logic signed [EW-1:0] e4_r   [9];
  logic signed [TW-1:0] dt_nxt [6];
  logic signed [TW-1:0] dt_r   [6];
  logic signed [DW-1:0] det;
  logic                 u3_r, u4_r;
  logic signed [FW-1:0] fm     [12];
  logic signed [W-1:0]  fp_r   [12];
  logic signed [W-1:0]  f_nxt  [6];
  logic signed [W-1:0]  f_r    [6];
  logic signed [W-1:0]  num_nxt, den_nxt, num_r, den_r;
  sls_pkg::zside_t      side_nxt, side_r;

  // Stage 1: pairwise coefficient products
  always_comb begin
    pe_nxt[0]  = a_i.r2_x_coef * a_i.r1_y_coef;
    pe_nxt[1]  = a_i.r1_x_coef * a_i.r2_y_coef;
    pe_nxt[2]  = a_i.r2_x_coef * a_i.r1_z_coef;
    pe_nxt[3]  = a_i.r1_x_coef * a_i.r2_z_coef;
    pe_nxt[4]  = a_i.r2_x_coef * a_i.r1_rhs;
    pe_nxt[5]  = a_i.r1_x_coef * a_i.r2_rhs;
    pe_nxt[6]  = a_i.r3_x_coef * a_i.r1_y_coef;
    pe_nxt[7]  = a_i.r1_x_coef * a_i.r3_y_coef;
    pe_nxt[8]  = a_i.r3_x_coef * a_i.r1_z_coef;
    pe_nxt[9]  = a_i.r1_x_coef * a_i.r3_z_coef;
    pe_nxt[10] = a_i.r3_x_coef * a_i.r1_rhs;
    pe_nxt[11] = a_i.r1_x_coef * a_i.r3_rhs;
    pe_nxt[12] = a_i.r2_x_coef * a_i.r3_y_coef;
    pe_nxt[13] = a_i.r3_x_coef * a_i.r2_y_coef;
    pe_nxt[14] = a_i.r2_x_coef * a_i.r3_z_coef;
    pe_nxt[15] = a_i.r3_x_coef * a_i.r2_z_coef;
    pe_nxt[16] = a_i.r2_x_coef * a_i.r3_rhs;
    pe_nxt[17] = a_i.r3_x_coef * a_i.r2_rhs;
    pd_nxt[0]  = a_i.r1_x_coef * a_i.r2_y_coef;
    pd_nxt[1]  = a_i.r1_y_coef * a_i.r2_z_coef;
    pd_nxt[2]  = a_i.r1_z_coef * a_i.r2_x_coef;
    pd_nxt[3]  = a_i.r1_x_coef * a_i.r2_z_coef;
    pd_nxt[4]  = a_i.r1_y_coef * a_i.r2_x_coef;
    pd_nxt[5]  = a_i.r1_z_coef * a_i.r2_y_coef;
  end

  // Stage 2: first elimination terms and determinant triple products
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e_nxt[k] = EW'(pe_r[2*k]) - EW'(pe_r[2*k+1]);
    end
    dt_nxt[0] = pd_r[0] * a1_r.r3_z_coef;
    dt_nxt[1] = pd_r[1] * a1_r.r3_x_coef;
    dt_nxt[2] = pd_r[2] * a1_r.r3_y_coef;
    dt_nxt[3] = pd_r[3] * a1_r.r3_y_coef;
    dt_nxt[4] = pd_r[4] * a1_r.r3_z_coef;
    dt_nxt[5] = pd_r[5] * a1_r.r3_x_coef;
  end

  // Stage 3: determinant sum and second elimination products
  assign det = DW'(dt_r[0]) + DW'(dt_r[1]) + DW'(dt_r[2])
             - DW'(dt_r[3]) - DW'(dt_r[4]) - DW'(dt_r[5]);

  assign fm[0]  = e2_r[3] * e2_r[1];
  assign fm[1]  = e2_r[0] * e2_r[4];
  assign fm[2]  = e2_r[3] * e2_r[2];
  assign fm[3]  = e2_r[0] * e2_r[5];
  assign fm[4]  = e2_r[6] * e2_r[1];
  assign fm[5]  = e2_r[0] * e2_r[7];
  assign fm[6]  = e2_r[6] * e2_r[2];
  assign fm[7]  = e2_r[0] * e2_r[8];
  assign fm[8]  = e2_r[3] * e2_r[7];
  assign fm[9]  = e2_r[6] * e2_r[4];
  assign fm[10] = e2_r[3] * e2_r[8];
  assign fm[11] = e2_r[6] * e2_r[5];

  // Stage 4: second elimination terms, wrapped to 64 bits
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      f_nxt[k] = fp_r[2*k] - fp_r[2*k+1];
    end
  end

  // Stage 5: pick the first nonzero z pivot
  always_comb begin
    if (f_r[0] != '0) begin
      num_nxt = f_r[1];
      den_nxt = f_r[0];
    end else if (f_r[2] != '0) begin
      num_nxt = f_r[3];
      den_nxt = f_r[2];
    end else begin
      num_nxt = f_r[5];
      den_nxt = f_r[4];
    end
    side_nxt.uniq = u4_r;
    side_nxt.e11  = e4_r[0];
    side_nxt.e12  = e4_r[1];
    side_nxt.e13  = e4_r[2];
    side_nxt.e21  = e4_r[3];
    side_nxt.e22  = e4_r[4];
    side_nxt.e23  = e4_r[5];
    side_nxt.e31  = e4_r[6];
    side_nxt.e32  = e4_r[7];
    side_nxt.e33  = e4_r[8];
    side_nxt.a    = a4_r;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    a1_r <= a_i;
    pe_r <= pe_nxt;
    pd_r <= pd_nxt;
    a2_r <= a1_r;
    e2_r <= e_nxt;
    dt_r <= dt_nxt;
    a3_r <= a2_r;
    e3_r <= e2_r;
    u3_r <= (det != '0);
    for (int k = 0; k < 12; k++) begin
      fp_r[k] <= fm[k][W-1:0];
    end
    a4_r   <= a3_r;
    e4_r   <= e3_r;
    u4_r   <= u3_r;
    f_r    <= f_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    side_r <= side_nxt;
  end

  assign valid_o = v5_r;
  assign num_o   = num_r;
  assign den_o   = den_r;
  assign side_o  = side_r;

endmodule
`default_nettype wire

// ----- sv/sls_num.sv -----
// Back-substitution numerator: picks the first nonzero pivot row and forms
// rhs * 2^16 - c1 * v1 - c2 * v2 in three stages. Depends on sls_pkg.
`default_nettype none
module sls_num #(
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  valid_i,
  input  logic [2:0][sls_pkg::E_W-1:0]          piv_i,
  input  logic [2:0][sls_pkg::E_W-1:0]          rhs_i,
  input  logic [2:0][sls_pkg::E_W-1:0]          c1_i,
  input  logic [2:0][sls_pkg::E_W-1:0]          c2_i,
  input  logic signed [sls_pkg::SOL_W-1:0]      v1_i,
  input  logic signed [sls_pkg::SOL_W-1:0]      v2_i,
  input  logic [SIDE_W-1:0]                     side_i,
  output logic                                  valid_o,
  output logic signed [sls_pkg::W64-1:0]        num_o,
  output logic signed [sls_pkg::W64-1:0]        den_o,
  output logic [SIDE_W-1:0]                     side_o
);

  localparam int EW = sls_pkg::E_W;
  localparam int SW = sls_pkg::SOL_W;
  localparam int W  = sls_pkg::W64;
  localparam int FB = sls_pkg::FRAC_BITS;
  localparam int MW = EW + SW;

  logic va_r, vb_r, vc_r;
  logic [SIDE_W-1:0] sa_r, sb_r, sc_r;
  logic [1:0] sel;
  logic signed [EW-1:0] pv_r, rh_r, k1_r, k2_r, pv2_r;
  logic signed [SW-1:0] x1_r, x2_r;
  logic signed [MW-1:0] p1, p2;
  logic signed [W-1:0]  p1_r, p2_r, rs_r, rs_nxt, num_r, den_r;

  // Stage A: first nonzero pivot row
  always_comb begin
    if (piv_i[0] != '0) begin
      sel = 2'd0;
    end else if (piv_i[1] != '0) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  // Stage B: products of known values and the scaled right-hand side
  assign p1 = k1_r * x1_r;
  assign p2 = k2_r * x2_r;
  assign rs_nxt = {{(W-EW-FB){rh_r[EW-1]}}, rh_r, {FB{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= valid_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    pv_r  <= piv_i[sel];
    rh_r  <= rhs_i[sel];
    k1_r  <= c1_i[sel];
    k2_r  <= c2_i[sel];
    x1_r  <= v1_i;
    x2_r  <= v2_i;
    sa_r  <= side_i;
    p1_r  <= p1[W-1:0];
    p2_r  <= p2[W-1:0];
    rs_r  <= rs_nxt;
    pv2_r <= pv_r;
    sb_r  <= sa_r;
    // Stage C: numerator and sign-extended divisor
    num_r <= rs_r - p1_r - p2_r;
    den_r <= {{(W-EW){pv2_r[EW-1]}}, pv2_r};
    sc_r  <= sb_r;
  end

  assign valid_o = vc_r;
  assign num_o   = num_r;
  assign den_o   = den_r;
  assign side_o  = sc_r;

endmodule
`default_nettype wire

// ----- sv/sls_div.sv -----
// Pipelined restoring divider: trunc(n * 2^s / d), s = 0 or 16, saturated to
// Q16.16, one quotient bit per stage. Depends on sls_pkg.
`default_nettype none
module sls_div #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_i,
  input  logic signed [sls_pkg::W64-1:0]    num_i,
  input  logic signed [sls_pkg::W64-1:0]    den_i,
  input  logic                              scale_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [sls_pkg::Q_BITS-1:0] q_o,
  output logic                              ovf_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int W   = sls_pkg::W64;
  localparam int QB  = sls_pkg::Q_BITS;
  localparam int FB  = sls_pkg::FRAC_BITS;
  localparam int DDW = W + FB;
  localparam logic [QB-1:0] Q_MAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] Q_MIN = {1'b1, {(QB-1){1'b0}}};

  logic [W-1:0]   un, ud;
  logic [DDW-1:0] dd;
  logic           big;

  logic              v_r    [0:QB];
  logic [W-1:0]      rem_r  [0:QB];
  logic [QB-1:0]     dlo_r  [0:QB];
  logic [QB-1:0]     q_r    [0:QB];
  logic [W-1:0]      ud_r   [0:QB];
  logic              neg_r  [0:QB];
  logic              dz_r   [0:QB];
  logic              big_r  [0:QB];
  logic [SIDE_W-1:0] side_r [0:QB];

  logic [QB-1:0]     m, qo_nxt, qo_r;
  logic              ovf_nxt, ovf_r, vo_r;
  logic [SIDE_W-1:0] so_r;

  // Setup: magnitudes, scaled dividend, quotient range check
  assign un  = num_i[W-1] ? (~num_i + W'(1)) : num_i;
  assign ud  = den_i[W-1] ? (~den_i + W'(1)) : den_i;
  assign dd  = scale_i ? {un, {FB{1'b0}}} : {{FB{1'b0}}, un};
  assign big = W'(dd[DDW-1:QB]) >= ud;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= W'(dd[DDW-1:QB]);
    dlo_r[0]  <= dd[QB-1:0];
    q_r[0]    <= '0;
    ud_r[0]   <= ud;
    neg_r[0]  <= num_i[W-1] ^ den_i[W-1];
    dz_r[0]   <= (den_i == '0);
    big_r[0]  <= big;
    side_r[0] <= side_i;
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [W:0] trial;
    logic       ge;

    assign trial = {rem_r[k], dlo_r[k][QB-1]};
    assign ge    = trial >= {1'b0, ud_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? W'(trial - {1'b0, ud_r[k]}) : trial[W-1:0];
      dlo_r[k+1]  <= {dlo_r[k][QB-2:0], 1'b0};
      q_r[k+1]    <= {q_r[k][QB-2:0], ge};
      ud_r[k+1]   <= ud_r[k];
      neg_r[k+1]  <= neg_r[k];
      dz_r[k+1]   <= dz_r[k];
      big_r[k+1]  <= big_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  // Apply sign and saturate
  assign m = q_r[QB];

  always_comb begin
    qo_nxt  = m;
    ovf_nxt = 1'b0;
    if (dz_r[QB]) begin
      qo_nxt  = '0;
      ovf_nxt = 1'b1;
    end else if (big_r[QB]) begin
      qo_nxt  = neg_r[QB] ? Q_MIN : Q_MAX;
      ovf_nxt = 1'b1;
    end else if (neg_r[QB]) begin
      if (m[QB-1] && (m[QB-2:0] != '0)) begin
        qo_nxt  = Q_MIN;
        ovf_nxt = 1'b1;
      end else begin
        qo_nxt = ~m + QB'(1);
      end
    end else if (m[QB-1]) begin
      qo_nxt  = Q_MAX;
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    qo_r  <= qo_nxt;
    ovf_r <= ovf_nxt;
    so_r  <= side_r[QB];
  end

  assign valid_o = vo_r;
  assign q_o     = qo_r;
  assign ovf_o   = ovf_r;
  assign side_o  = so_r;

endmodule
`default_nettype wire

// ----- sv/solve_linear_system_3x3.sv -----
// 3x3 linear system solver, top level. Depends on sls_pkg, sls_elim, sls_num, sls_div.
// Throughput: one request per clock; busy stays low, and the elimination stages,
// three 34-stage dividers (z, y, x) and two three-stage numerator units run in lockstep.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
`default_nettype none
module solve_linear_system_3x3 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sls_pkg::in_t  in_data,
  output logic          out_valid,
  output sls_pkg::out_t out_data
);

  localparam int W  = sls_pkg::W64;
  localparam int SW = sls_pkg::SOL_W;
  localparam int EW = sls_pkg::E_W;

  logic                 e_v, zd_v, yn_v, yd_v, xn_v, xd_v;
  logic signed [W-1:0]  e_num, e_den, yn_num, yn_den, xn_num, xn_den;
  sls_pkg::zside_t      e_side, zd_side;
  sls_pkg::yside_t      yn_side_in, yn_side, yd_side;
  sls_pkg::xside_t      xn_side_in, xn_side, xd_side;
  logic signed [SW-1:0] zq, yq, xq;
  logic                 zovf, yovf, xovf;
  logic                 ov_r;
  sls_pkg::out_t        od_r, od_nxt;

  assign busy = 1'b0;

  sls_elim u_elim (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .a_i     (in_data),
    .valid_o (e_v),
    .num_o   (e_num),
    .den_o   (e_den),
    .side_o  (e_side)
  );

  // z = f_num * 2^16 / f_piv
  sls_div #(.SIDE_W($bits(sls_pkg::zside_t))) u_zdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (e_v),
    .num_i   (e_num),
    .den_i   (e_den),
    .scale_i (1'b1),
    .side_i  (e_side),
    .valid_o (zd_v),
    .q_o     (zq),
    .ovf_o   (zovf),
    .side_o  (zd_side)
  );

  // y numerator over the first elimination rows
  always_comb begin
    yn_side_in.uniq = zd_side.uniq;
    yn_side_in.ovf  = zovf;
    yn_side_in.z    = zq;
    yn_side_in.a    = zd_side.a;
  end

  sls_num #(.SIDE_W($bits(sls_pkg::yside_t))) u_ynum (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (zd_v),
    .piv_i   ({zd_side.e31, zd_side.e21, zd_side.e11}),
    .rhs_i   ({zd_side.e33, zd_side.e23, zd_side.e13}),
    .c1_i    ({zd_side.e32, zd_side.e22, zd_side.e12}),
    .c2_i    ({(3*EW){1'b0}}),
    .v1_i    (zq),
    .v2_i    ({SW{1'b0}}),
    .side_i  (yn_side_in),
    .valid_o (yn_v),
    .num_o   (yn_num),
    .den_o   (yn_den),
    .side_o  (yn_side)
  );

  sls_div #(.SIDE_W($bits(sls_pkg::yside_t))) u_ydiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (yn_v),
    .num_i   (yn_num),
    .den_i   (yn_den),
    .scale_i (1'b0),
    .side_i  (yn_side),
    .valid_o (yd_v),
    .q_o     (yq),
    .ovf_o   (yovf),
    .side_o  (yd_side)
  );

  // x numerator over the original rows
  always_comb begin
    xn_side_in.uniq = yd_side.uniq;
    xn_side_in.ovf  = yd_side.ovf | yovf;
    xn_side_in.y    = yq;
    xn_side_in.z    = yd_side.z;
  end

  sls_num #(.SIDE_W($bits(sls_pkg::xside_t))) u_xnum (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (yd_v),
    .piv_i   ({sls_pkg::e_t'(yd_side.a.r3_x_coef), sls_pkg::e_t'(yd_side.a.r2_x_coef),
               sls_pkg::e_t'(yd_side.a.r1_x_coef)}),
    .rhs_i   ({sls_pkg::e_t'(yd_side.a.r3_rhs), sls_pkg::e_t'(yd_side.a.r2_rhs),
               sls_pkg::e_t'(yd_side.a.r1_rhs)}),
    .c1_i    ({sls_pkg::e_t'(yd_side.a.r3_y_coef), sls_pkg::e_t'(yd_side.a.r2_y_coef),
               sls_pkg::e_t'(yd_side.a.r1_y_coef)}),
    .c2_i    ({sls_pkg::e_t'(yd_side.a.r3_z_coef), sls_pkg::e_t'(yd_side.a.r2_z_coef),
               sls_pkg::e_t'(yd_side.a.r1_z_coef)}),
    .v1_i    (yq),
    .v2_i    (yd_side.z),
    .side_i  (xn_side_in),
    .valid_o (xn_v),
    .num_o   (xn_num),
    .den_o   (xn_den),
    .side_o  (xn_side)
  );

  sls_div #(.SIDE_W($bits(sls_pkg::xside_t))) u_xdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (xn_v),
    .num_i   (xn_num),
    .den_i   (xn_den),
    .scale_i (1'b0),
    .side_i  (xn_side),
    .valid_o (xd_v),
    .q_o     (xq),
    .ovf_o   (xovf),
    .side_o  (xd_side)
  );

  // Drop the solution when the determinant is zero
  always_comb begin
    if (xd_side.uniq) begin
      od_nxt.sol_x    = xq;
      od_nxt.sol_y    = xd_side.y;
      od_nxt.sol_z    = xd_side.z;
      od_nxt.overflow = xd_side.ovf | xovf;
    end else begin
      od_nxt.sol_x    = '0;
      od_nxt.sol_y    = '0;
      od_nxt.sol_z    = '0;
      od_nxt.overflow = 1'b0;
    end
    od_nxt.unique_solution = xd_side.uniq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= xd_v;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
`default_nettype wire

// ----- sv/sls_checker.sv -----
// Port-level checks for the solver top level, bound to every instance.
// Depends on sls_pkg and solve_linear_system_3x3.
`default_nettype none
module sls_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input sls_pkg::out_t out_data
);

  // Reset drops every request in flight
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Each request yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(sls_pkg::LATENCY) out_valid)
    else $error("missing result for accepted request");

  // No result without a request at the fixed latency
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, sls_pkg::LATENCY))
    else $error("result without request");

  // Singular systems give all-zero results and no overflow
  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.unique_solution) |->
      (out_data.sol_x == '0 && out_data.sol_y == '0 && out_data.sol_z == '0
       && !out_data.overflow))
    else $error("nonzero result for singular system");

endmodule

bind solve_linear_system_3x3 sls_checker u_sls_checker (.*);
`default_nettype wire
